### src/ttl_pkg.sv
package ttl_pkg;

  localparam int SAMPLE_BITS   = 14;
  localparam int TABLE_POINTS  = 20;
  localparam int FRACTION_BITS = 4;
  localparam int IDX_BITS      = $clog2(TABLE_POINTS + 1);
  localparam int Y_BITS        = 9;
  localparam int DY_BITS       = 8;
  localparam int OFF_BITS      = 10;
  localparam int BASE_BITS     = 19;
  localparam int TOTAL_BITS    = 21;
  localparam int NUM_BITS      = BASE_BITS + FRACTION_BITS;
  localparam int TEMP_BITS     = 12;
  localparam int RECIP_SHIFT   = 33;
  localparam int RECIP_BITS    = 24;
  localparam int Q_BITS        = NUM_BITS + RECIP_BITS - RECIP_SHIFT;

  // breakpoints sit on a uniform 819-count grid
  localparam logic [OFF_BITS-1:0] DX = 10'd819;

  localparam logic [SAMPLE_BITS-1:0] BP_X [TABLE_POINTS] = '{
    14'd700,   14'd1519,  14'd2338,  14'd3157,
    14'd3976,  14'd4795,  14'd5614,  14'd6433,
    14'd7252,  14'd8071,  14'd8890,  14'd9709,
    14'd10528, 14'd11347, 14'd12166, 14'd12985,
    14'd13804, 14'd14623, 14'd15442, 14'd16261
  };

  localparam logic [Y_BITS-1:0] BP_Y [TABLE_POINTS] = '{
    9'd440, 9'd347, 9'd303, 9'd274,
    9'd253, 9'd235, 9'd221, 9'd208,
    9'd196, 9'd185, 9'd174, 9'd164,
    9'd154, 9'd144, 9'd133, 9'd122,
    9'd109, 9'd93,  9'd72,  9'd18
  };

  localparam logic [TEMP_BITS-1:0] TEMP_MAX = TEMP_BITS'(255 << FRACTION_BITS);
  localparam int BELOW_RAW = int'(BP_Y[0]) << FRACTION_BITS;
  localparam logic [TEMP_BITS-1:0] BELOW_TEMP =
    (BELOW_RAW > int'(TEMP_MAX)) ? TEMP_MAX : TEMP_BITS'(BELOW_RAW);

  // floor(2^33 / 819); quotient estimate is low by at most one
  localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'((64'd1 << RECIP_SHIFT) / DX);

  typedef enum logic [1:0] {
    STAT_INTERP = 2'd0,
    STAT_BELOW  = 2'd1,
    STAT_BEYOND = 2'd2
  } status_t;

  typedef struct packed {
    logic [NUM_BITS-1:0] num;
    status_t             status;
  } div_in_t;

  typedef struct packed {
    logic [TEMP_BITS-1:0] temp;
    status_t              status;
  } div_out_t;

endpackage

### src/thermistor_table_linearizer.sv
// Throughput: one sample per cycle while out_ready does not stall the pipe; no hazards between samples.
// Stages: segment search, breakpoint fetch, interpolation multiply-add,
// reciprocal multiply, correction/clamp into the output register.
// Reset: synchronous, active low; clears all stage valid bits only.
module thermistor_table_linearizer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ttl_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ttl_pkg::TEMP_BITS-1:0]   out_temperature,
  output logic [1:0]                      out_status
);
  import ttl_pkg::*;

  // Each stage moves when it is empty or the stage after it moves, so
  // bubbles collapse and a full pipe stalls without dropping anything.
  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;
  logic div_ready;

  // stage 1: segment index = number of breakpoints at or below the sample
  logic [IDX_BITS-1:0]    idx_nxt, idx1_r;
  logic [SAMPLE_BITS-1:0] s1_r;

  // stage 2: breakpoint fetch
  logic [IDX_BITS-1:0]    lo, hi;
  status_t                stat_nxt, stat2_r, stat3_r;
  logic [BASE_BITS-1:0]   base_nxt, base2_r;
  logic signed [DY_BITS-1:0] dy_nxt, dy2_r;
  logic [OFF_BITS-1:0]    off_nxt, off2_r;

  // stage 3: total = y0*dx + dy*(s-x0), scaled by the fraction bits
  logic signed [TOTAL_BITS-1:0] total;
  logic [NUM_BITS-1:0]    num_nxt, num3_r;

  div_in_t  div_in;
  div_out_t div_out;

  assign adv3     = !v3_r || div_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  // Breakpoint x rises, so the compares form a thermometer code; the last
  // hit gives the segment index.
  always_comb begin
    idx_nxt = '0;
    for (int i = 0; i < TABLE_POINTS; i++) begin
      if (in_sample >= BP_X[i]) idx_nxt = IDX_BITS'(i + 1);
    end
  end

  // Index 0 is below the table, index TABLE_POINTS is at or past the end.
  // Out-of-table cases fetch segment 0 just to keep the lookup in range.
  always_comb begin
    if (idx1_r == '0) begin
      stat_nxt = STAT_BELOW;
      lo       = '0;
      hi       = IDX_BITS'(1);
    end else if (idx1_r >= IDX_BITS'(TABLE_POINTS)) begin
      stat_nxt = STAT_BEYOND;
      lo       = '0;
      hi       = IDX_BITS'(1);
    end else begin
      stat_nxt = STAT_INTERP;
      lo       = idx1_r - IDX_BITS'(1);
      hi       = idx1_r;
    end
    base_nxt = BASE_BITS'(BP_Y[lo]) * BASE_BITS'(DX);
    dy_nxt   = DY_BITS'({1'b0, BP_Y[hi]} - {1'b0, BP_Y[lo]});
    off_nxt  = OFF_BITS'(s1_r - BP_X[lo]);
  end

  // y falls along the table, so dy is negative and total never exceeds base.
  always_comb begin
    total = signed'(TOTAL_BITS'(base2_r))
          + TOTAL_BITS'(dy2_r * signed'({1'b0, off2_r}));
    if (total <= 0) num_nxt = '0;
    else            num_nxt = {total[BASE_BITS-1:0], FRACTION_BITS'(0)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      idx1_r <= idx_nxt;
      s1_r   <= in_sample;
    end
    if (adv2) begin
      stat2_r <= stat_nxt;
      base2_r <= base_nxt;
      dy2_r   <= dy_nxt;
      off2_r  <= off_nxt;
    end
    if (adv3) begin
      stat3_r <= stat2_r;
      num3_r  <= num_nxt;
    end
  end

  assign div_in.num    = num3_r;
  assign div_in.status = stat3_r;

  // divide by the segment width, clamp, and hold the result for the sink
  ttl_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_ready  (div_ready),
    .in_data   (div_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (div_out)
  );

  assign out_temperature = div_out.temp;
  assign out_status      = div_out.status;

endmodule

### src/ttl_div.sv
module ttl_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ttl_pkg::div_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ttl_pkg::div_out_t out_data
);
  import ttl_pkg::*;

  localparam int PROD_BITS = NUM_BITS + RECIP_BITS;

  logic                  va_r, vb_r;
  logic                  adv_a, adv_b;
  logic [NUM_BITS-1:0]   num_a_r;
  logic [Q_BITS-1:0]     q0_a_r;
  status_t               stat_a_r;
  div_out_t              out_r;

  logic [PROD_BITS-1:0]  prod;
  logic [NUM_BITS-1:0]   qdx;
  logic [NUM_BITS-1:0]   rem;
  logic [Q_BITS-1:0]     q;
  div_out_t              out_nxt;

  assign adv_b    = !vb_r || out_ready;
  assign adv_a    = !va_r || adv_b;
  assign in_ready = adv_a;

  // reciprocal estimate
  assign prod = PROD_BITS'(in_data.num) * PROD_BITS'(RECIP);

  // correction step and clamp
  always_comb begin
    qdx = NUM_BITS'(q0_a_r) * NUM_BITS'(DX);
    rem = num_a_r - qdx;
    q   = (rem >= NUM_BITS'(DX)) ? q0_a_r + Q_BITS'(1) : q0_a_r;
    out_nxt.status = stat_a_r;
    case (stat_a_r)
      STAT_BELOW:  out_nxt.temp = BELOW_TEMP;
      STAT_BEYOND: out_nxt.temp = '0;
      default: begin
        out_nxt.temp = (q > Q_BITS'(TEMP_MAX)) ? TEMP_MAX : q[TEMP_BITS-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (adv_a) va_r <= in_valid;
      if (adv_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      num_a_r  <= in_data.num;
      q0_a_r   <= prod[PROD_BITS-1 -: Q_BITS];
      stat_a_r <= in_data.status;
    end
    if (adv_b) out_r <= out_nxt;
  end

  assign out_valid = vb_r;
  assign out_data  = out_r;

endmodule

### src/ttl_checker.sv
module ttl_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [ttl_pkg::TEMP_BITS-1:0]   out_temperature,
  input logic [1:0]                      out_status
);
  import ttl_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_temperature)
                                && $stable(out_status))
    else $error("stalled result changed");

  a_beyond_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_BEYOND |-> out_temperature == '0)
    else $error("beyond-table result not zero");

  a_below_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_BELOW |-> out_temperature == BELOW_TEMP)
    else $error("below-table result not saturated");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_temperature <= TEMP_MAX && out_status != 2'd3)
    else $error("result out of range");

endmodule

bind thermistor_table_linearizer ttl_checker u_ttl_checker (.*);

### verif/thermistor_table_linearizer_tb.sv
module thermistor_table_linearizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttl_pkg::*;

  localparam int RANDOM_SAMPLES = 2000;
  localparam int DRAIN_LIMIT    = 20000;
  // pipeline is 5 deep; give it some slack after the last result
  localparam int SETTLE_CYCLES  = 20;
  // breakpoints sit on a uniform grid: x = GRID_START + GRID_STEP * j
  localparam int GRID_START     = 700;
  localparam int GRID_STEP      = 819;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [TEMP_BITS-1:0]   temp_t;

  typedef struct {
    sample_t   sample;
    temp_t     temp;
    status_t   status;
  } reading_t;

  // Scoreboard: holds the predicted reading for every accepted request and
  // checks results against them in order.
  class temp_scoreboard;
    localparam int NUM_POINTS = 20;
    localparam int FRAC       = 4;
    localparam int TEMP_LIMIT = 255;
    localparam int CURVE_X [NUM_POINTS] = '{
      700,   1519,  2338,  3157,  3976,  4795,  5614,  6433,  7252,  8071,
      8890,  9709,  10528, 11347, 12166, 12985, 13804, 14623, 15442, 16261
    };
    localparam int CURVE_Y [NUM_POINTS] = '{
      440, 347, 303, 274, 253, 235, 221, 208, 196, 185,
      174, 164, 154, 144, 133, 122, 109, 93,  72,  18
    };

    reading_t pending_readings[$];
    int       error_count;

    function new();
      error_count = 0;
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction

    function temp_t clamp_fixed(longint v);
      longint lim;
      lim = longint'(TEMP_LIMIT) << FRAC;
      if (v < 0) return '0;
      return temp_t'((v > lim) ? lim : v);
    endfunction

    function reading_t predict_temperature(sample_t s);
      reading_t r;
      int       seg;
      int       k;
      longint   x0, y0, dx, dy, total;
      r.sample = s;
      // first breakpoint strictly above the sample
      seg = NUM_POINTS;
      for (k = NUM_POINTS - 1; k >= 0; k--)
        if (CURVE_X[k] > int'(s)) seg = k;
      if (seg == 0) begin
        r.status = STAT_BELOW;
        r.temp   = clamp_fixed(longint'(CURVE_Y[0]) << FRAC);
      end else if (seg == NUM_POINTS) begin
        r.status = STAT_BEYOND;
        r.temp   = '0;
      end else begin
        r.status = STAT_INTERP;
        x0 = CURVE_X[seg-1];
        y0 = CURVE_Y[seg-1];
        dx = longint'(CURVE_X[seg]) - x0;
        dy = longint'(CURVE_Y[seg]) - y0;
        if (dx <= 0) begin
          r.temp = clamp_fixed(y0 << FRAC);
        end else begin
          total = y0 * dx + dy * (longint'(s) - x0);
          r.temp = (total <= 0) ? '0 : clamp_fixed((total << FRAC) / dx);
        end
      end
      return r;
    endfunction

    task report(string what);
      error_count++;
      $display("[%0t] ERROR: %s", $realtime, what);
    endtask

    task note_request(sample_t s);
      pending_readings.push_back(predict_temperature(s));
    endtask

    task check_result(temp_t temp, logic [1:0] status);
      reading_t exp_r;
      if (pending_readings.size() == 0) begin
        report($sformatf("result temp=%0d status=%0d with no request outstanding",
                         temp, status));
        return;
      end
      exp_r = pending_readings.pop_front();
      if (temp !== exp_r.temp)
        report($sformatf("sample %0d: temperature %0d, expected %0d",
                         exp_r.sample, temp, exp_r.temp));
      if (status !== 2'(exp_r.status))
        report($sformatf("sample %0d: status %0d, expected %0d",
                         exp_r.sample, status, exp_r.status));
    endtask
  endclass

  logic    clk;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_ready;
  sample_t in_sample = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  temp_t   out_temperature;
  logic [1:0] out_status;

  temp_scoreboard sb = new();

  thermistor_table_linearizer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_temperature (out_temperature),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the pipeline hangs or the drain never completes.
  initial begin
    #2000000;
    $display("thermistor_table_linearizer test failed");
    $finish;
  end

  // Handshake monitor. Everything here reads pre-edge values, since all
  // testbench drives are nonblocking. Requests are noted before results are
  // checked so a same-edge pair can never race.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_request(in_sample);
      if (out_valid === 1'b1 && out_ready)
        sb.check_result(out_temperature, out_status);
    end
  end

  // Receiver backpressure: phases of random length, each with its own
  // stall pattern (always ready, ~50%, ~25%, short repeating pattern).
  initial begin
    int          mode;
    int          len;
    int          n;
    logic [31:0] pattern;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode    = $urandom_range(0, 3);
      len     = $urandom_range(16, 200);
      pattern = $urandom | 32'h1;
      for (n = 0; n < len; n++) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= pattern[n % 32];
          2: out_ready <= pattern[n % 32] & pattern[(n + 7) % 32];
          default: out_ready <= pattern[n % 8];
        endcase
        @(posedge clk);
      end
    end
  end

  // Present one request and hold it until accepted. Valid is not lowered
  // here, so back-to-back requests keep it high without a glitch.
  task automatic send_sample(input sample_t s);
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      in_valid  <= 1'b0;
      in_sample <= sample_t'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold off until every outstanding request has produced its result, or the drain guard runs out.
  // One edge first so the last accepted request has been noted.
  task automatic wait_for_drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    @(posedge clk);
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // Random sample mix: lots of hits right around the breakpoints, plus
  // uniform values and both out-of-table regions.
  function automatic sample_t pick_sample();
    int sel;
    int v;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: v = $urandom_range(0, (1 << SAMPLE_BITS) - 1);
      4, 5, 6: v = GRID_START + GRID_STEP * $urandom_range(0, 19)
                   + $urandom_range(0, 6) - 3;
      7: v = $urandom_range(0, GRID_START - 1);
      8: v = $urandom_range(GRID_START + GRID_STEP * 19, (1 << SAMPLE_BITS) - 1);
      default: v = $urandom;
    endcase
    return sample_t'(v);
  endfunction

  // Directed corners: all-zero/all-one samples, both sides of the first and
  // last breakpoints, several interior breakpoints, alternating bit patterns.
  sample_t corner_samples[$] = '{
    14'd0,     14'd1,     14'd699,   14'd700,   14'd701,
    14'd1518,  14'd1519,  14'd1520,  14'd4795,  14'd8070,
    14'd8071,  14'd8072,  14'd8191,  14'd8192,  14'd15441,
    14'd15442, 14'd15443, 14'd16260, 14'd16261, 14'd16262,
    14'd16383, 14'h2AAA,  14'h1555
  };

  initial begin
    int sent;
    int burst;
    int b;
    // synchronous reset held at the start, then released once
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_samples[i])
      send_sample(corner_samples[i]);
    // pipeline must empty completely before the random part starts
    wait_for_drain();

    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                          : $urandom_range(1, 40);
      for (b = 0; b < burst && sent < RANDOM_SAMPLES; b++) begin
        send_sample(pick_sample());
        sent++;
      end
      if ($urandom_range(0, 14) == 0)
        wait_for_drain();
      else if ($urandom_range(0, 5) == 0)
        idle_cycles($urandom_range(5, 20));
      else
        idle_cycles($urandom_range(0, 3));
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));

    if (sb.error_count == 0)
      $display("thermistor_table_linearizer test passed");
    else
      $display("thermistor_table_linearizer test failed");
    $finish;
  end

endmodule

### thermistor_table_linearizer.f
src/ttl_pkg.sv
src/ttl_div.sv
src/thermistor_table_linearizer.sv
src/ttl_checker.sv
verif/thermistor_table_linearizer_tb.sv
